// ===== rtl/bsd_pkg.sv =====
`timescale 1ns / 1ps

package bsd_pkg;

   localparam int PORT_W      = 2;
   localparam int COUNT_W     = 32;
   localparam int RATE_W      = 39;
   localparam int THRESH_W    = 40;
   localparam int RESP_W      = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int OVER_W      = 3;
   localparam int QUIET_W     = 3;
   localparam int RECOVER_W   = 2;

   localparam int RATE_SCALE    = 100;
   localparam int OVER_LIMIT    = 3;
   localparam int QUIET_LIMIT   = 3;
   localparam int RECOVER_LIMIT = 2;

   typedef enum logic [RESP_W-1:0] {
      RESP_NONE     = 3'd0,
      RESP_SHUTDOWN = 3'd1,
      RESP_LIMIT    = 3'd2,
      RESP_UNLIMIT  = 3'd3,
      RESP_ENDED    = 3'd4
   } response_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_SHUTDOWN  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic update;
      logic up;
      logic storming;
      logic shutdown;
   } hyst_ctl_type;

endpackage

// ===== rtl/bsd_if.sv =====
`timescale 1ns / 1ps

interface bsd_req_if;
   logic                           valid;
   logic                           ready;
   logic [bsd_pkg::PORT_W-1:0]     port_index;
   logic                           port_up;
   logic [bsd_pkg::COUNT_W-1:0]    rx_bcast_count;
   logic [bsd_pkg::COUNT_W-1:0]    tx_bcast_count;
   logic [bsd_pkg::COUNT_W-1:0]    now_tick;

   modport source (output valid, port_index, port_up, rx_bcast_count, tx_bcast_count,
                   now_tick, input ready);
   modport sink   (input valid, port_index, port_up, rx_bcast_count, tx_bcast_count,
                   now_tick, output ready);
endinterface

interface bsd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsd_pkg::PORT_W-1:0]    port_out;
   logic [bsd_pkg::RESP_W-1:0]    response;
   logic [bsd_pkg::RATE_W-1:0]    rx_rate;
   logic [bsd_pkg::RATE_W-1:0]    tx_rate;

   modport source (output valid, port_out, response, rx_rate, tx_rate, input ready);
   modport sink   (input valid, port_out, response, rx_rate, tx_rate, output ready);
endinterface

// ===== rtl/bsd_serial_div.sv =====
`timescale 1ns / 1ps

module bsd_serial_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bsd_pkg::RATE_W-1:0]       dividend,
   input  logic [bsd_pkg::COUNT_W-1:0]      divisor,
   output logic                             done,
   output logic [bsd_pkg::RATE_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(bsd_pkg::RATE_W + 1);

   logic [bsd_pkg::RATE_W-1:0]  shift_ff;
   logic [bsd_pkg::COUNT_W-1:0] rem_ff;
   logic [bsd_pkg::COUNT_W-1:0] divisor_ff;
   logic [CNT_W-1:0]            count_ff;
   logic                        busy_ff;
   logic                        done_ff;

   logic [bsd_pkg::COUNT_W:0]   trial;
   logic [bsd_pkg::COUNT_W:0]   diff;
   logic                        fits;

   assign trial = {rem_ff, shift_ff[bsd_pkg::RATE_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         shift_ff   <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
         count_ff   <= CNT_W'(bsd_pkg::RATE_W);
         busy_ff    <= 1'b1;
         done_ff    <= 1'b0;
      end else if (busy_ff) begin
         // shift in one quotient bit per cycle
         shift_ff <= {shift_ff[bsd_pkg::RATE_W-2:0], fits};
         rem_ff   <= fits ? diff[bsd_pkg::COUNT_W-1:0] : trial[bsd_pkg::COUNT_W-1:0];
         count_ff <= count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

// ===== rtl/bsd_port_state.sv =====
`timescale 1ns / 1ps

module bsd_port_state #(
   parameter int NUM_PORTS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bsd_pkg::PORT_W-1:0]     port,
   input  bsd_pkg::hyst_ctl_type          ctl,
   input  logic [bsd_pkg::COUNT_W-1:0]    rx_count,
   input  logic [bsd_pkg::COUNT_W-1:0]    tx_count,
   input  logic [bsd_pkg::COUNT_W-1:0]    now_tick,
   output logic                           in_range,
   output logic [bsd_pkg::COUNT_W-1:0]    last_rx,
   output logic [bsd_pkg::COUNT_W-1:0]    last_tx,
   output logic [bsd_pkg::COUNT_W-1:0]    last_tick,
   output bsd_pkg::response_type          response
);

   localparam int MAX_SLOTS  = 2 ** bsd_pkg::PORT_W;
   localparam int PORT_SLOTS = (NUM_PORTS < MAX_SLOTS) ? NUM_PORTS : MAX_SLOTS;
   localparam int SLOT_W     = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;

   logic [bsd_pkg::COUNT_W-1:0]   last_rx_ff   [PORT_SLOTS];
   logic [bsd_pkg::COUNT_W-1:0]   last_tx_ff   [PORT_SLOTS];
   logic [bsd_pkg::COUNT_W-1:0]   last_tick_ff [PORT_SLOTS];
   logic [bsd_pkg::OVER_W-1:0]    over_ff      [PORT_SLOTS];
   logic [bsd_pkg::QUIET_W-1:0]   quiet_ff     [PORT_SLOTS];
   logic [bsd_pkg::RECOVER_W-1:0] recover_ff   [PORT_SLOTS];
   logic                          armed_ff     [PORT_SLOTS];
   logic                          limit_ff     [PORT_SLOTS];

   logic [SLOT_W-1:0]             slot;
   logic [bsd_pkg::OVER_W-1:0]    over_in;
   logic [bsd_pkg::QUIET_W-1:0]   quiet_in;
   logic [bsd_pkg::RECOVER_W-1:0] recover_in;
   logic                          armed_in;
   logic                          limit_in;
   bsd_pkg::response_type         response_in;

   assign slot      = port[SLOT_W-1:0];
   assign in_range  = int'(port) < NUM_PORTS;
   assign last_rx   = last_rx_ff[slot];
   assign last_tx   = last_tx_ff[slot];
   assign last_tick = last_tick_ff[slot];

   always_comb begin
      over_in     = over_ff[slot];
      quiet_in    = quiet_ff[slot];
      recover_in  = recover_ff[slot];
      armed_in    = armed_ff[slot];
      limit_in    = limit_ff[slot];
      response_in = bsd_pkg::RESP_NONE;
      if (in_range && ctl.up) begin
         if (ctl.storming) begin
            over_in    = over_in + bsd_pkg::OVER_W'(1);
            quiet_in   = '0;
            recover_in = '0;
            if (over_in > bsd_pkg::OVER_W'(bsd_pkg::OVER_LIMIT)) begin
               if (ctl.shutdown) begin
                  response_in = bsd_pkg::RESP_SHUTDOWN;
               end else if (!limit_in) begin
                  response_in = bsd_pkg::RESP_LIMIT;
                  limit_in    = 1'b1;
               end
               over_in = '0;
            end
         end else begin
            over_in    = '0;
            recover_in = armed_in ? recover_in + bsd_pkg::RECOVER_W'(1) : '0;
            if (limit_in) begin
               quiet_in = quiet_in + bsd_pkg::QUIET_W'(1);
               if (quiet_in > bsd_pkg::QUIET_W'(bsd_pkg::QUIET_LIMIT)) begin
                  response_in = bsd_pkg::RESP_UNLIMIT;
                  armed_in    = 1'b1;
                  recover_in  = '0;
                  limit_in    = 1'b0;
               end
            end
            if (recover_in > bsd_pkg::RECOVER_W'(bsd_pkg::RECOVER_LIMIT)) begin
               response_in = bsd_pkg::RESP_ENDED;
               armed_in    = 1'b0;
               recover_in  = '0;
            end
         end
      end
   end

   assign response = response_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORT_SLOTS; i++) begin
            last_rx_ff[i]   <= '0;
            last_tx_ff[i]   <= '0;
            last_tick_ff[i] <= '0;
            over_ff[i]      <= '0;
            quiet_ff[i]     <= '0;
            recover_ff[i]   <= '0;
            armed_ff[i]     <= 1'b0;
            limit_ff[i]     <= 1'b0;
         end
      end else if (ctl.update && in_range) begin
         if (ctl.up) begin
            last_rx_ff[slot]   <= rx_count;
            last_tx_ff[slot]   <= tx_count;
            last_tick_ff[slot] <= now_tick;
            over_ff[slot]      <= over_in;
            quiet_ff[slot]     <= quiet_in;
            recover_ff[slot]   <= recover_in;
            armed_ff[slot]     <= armed_in;
            limit_ff[slot]     <= limit_in;
         end else begin
            // down port: drop rate history, keep hysteresis
            last_rx_ff[slot]   <= '0;
            last_tx_ff[slot]   <= '0;
            last_tick_ff[slot] <= '0;
         end
      end
   end

endmodule

// ===== rtl/broadcast_storm_detector.sv =====
`timescale 1ns / 1ps

// Broadcast storm detector. Each transfer on req carries one poll of one port:
// admin state, broadcast rx/tx counters and the current tick. Each poll gives
// exactly one transfer on rsp with the port, the action code and both rates,
// where a rate is floor(delta * 100 / interval) with wrap-aware deltas.
// An up port in range passes the delta and scale states, then the 39-step
// bit-serial dividers (rx and tx run side by side), then the finish state that
// registers rsp valid. A down port or a port beyond NUM_PORTS goes from delta
// straight to finish. One poll is in work at a time; req.ready is high again
// as soon as the result is registered, so a new poll waits until then.
// The rsp register holds its result while rsp.ready is low; a new poll is
// accepted and computed meanwhile and waits for that register to drain.
// The csr port sets storm_threshold (index 0) and shutdown_mode (index 1);
// write it only while no poll is in work.
// Reset clears all per-port history and counters, sets the threshold to all
// ones and selects rate limiting instead of shutdown.
module broadcast_storm_detector #(
   parameter int NUM_PORTS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   bsd_req_if.sink                            req,
   bsd_rsp_if.source                          rsp,
   input  logic                               csr_write_enable,
   input  logic [bsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bsd_pkg::THRESH_W-1:0]       csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELTA,
      ST_SCALE,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type                     state_ff;
   logic [bsd_pkg::PORT_W-1:0]    port_ff;
   logic                          up_ff;
   logic [bsd_pkg::COUNT_W-1:0]   rx_ff;
   logic [bsd_pkg::COUNT_W-1:0]   tx_ff;
   logic [bsd_pkg::COUNT_W-1:0]   now_ff;
   logic                          skip_ff;
   logic [bsd_pkg::COUNT_W-1:0]   interval_ff;
   logic [bsd_pkg::COUNT_W-1:0]   rx_delta_ff;
   logic [bsd_pkg::COUNT_W-1:0]   tx_delta_ff;
   logic [bsd_pkg::RATE_W-1:0]    rx_scaled_ff;
   logic [bsd_pkg::RATE_W-1:0]    tx_scaled_ff;
   logic                          div_start_ff;
   logic [bsd_pkg::THRESH_W-1:0]  threshold_ff;
   logic                          shutdown_ff;
   logic                          rsp_valid_ff;
   logic [bsd_pkg::PORT_W-1:0]    rsp_port_ff;
   logic [bsd_pkg::RESP_W-1:0]    rsp_response_ff;
   logic [bsd_pkg::RATE_W-1:0]    rsp_rx_rate_ff;
   logic [bsd_pkg::RATE_W-1:0]    rsp_tx_rate_ff;

   logic                          in_range;
   logic [bsd_pkg::COUNT_W-1:0]   last_rx;
   logic [bsd_pkg::COUNT_W-1:0]   last_tx;
   logic [bsd_pkg::COUNT_W-1:0]   last_tick;
   bsd_pkg::response_type         response;
   bsd_pkg::hyst_ctl_type         hyst_ctl;

   logic [bsd_pkg::COUNT_W-1:0]   tick_diff;
   logic [bsd_pkg::COUNT_W-1:0]   interval_in;
   logic [bsd_pkg::COUNT_W-1:0]   rx_diff;
   logic [bsd_pkg::COUNT_W-1:0]   tx_diff;
   logic [bsd_pkg::COUNT_W-1:0]   rx_delta_in;
   logic [bsd_pkg::COUNT_W-1:0]   tx_delta_in;
   logic [bsd_pkg::RATE_W-1:0]    rx_quot;
   logic [bsd_pkg::RATE_W-1:0]    tx_quot;
   logic                          rx_done;
   logic                          tx_done;
   logic [bsd_pkg::RATE_W-1:0]    rx_rate_in;
   logic [bsd_pkg::RATE_W-1:0]    tx_rate_in;
   logic                          rsp_free;
   logic                          req_xfer;

   assign req_xfer = req.valid && req.ready;
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   assign tick_diff   = now_ff - last_tick;
   assign interval_in = (now_ff > last_tick) ? tick_diff : tick_diff - bsd_pkg::COUNT_W'(1);
   assign rx_diff     = rx_ff - last_rx;
   assign tx_diff     = tx_ff - last_tx;
   assign rx_delta_in = (rx_ff >= last_rx) ? rx_diff : rx_diff - bsd_pkg::COUNT_W'(1);
   assign tx_delta_in = (tx_ff >= last_tx) ? tx_diff : tx_diff - bsd_pkg::COUNT_W'(1);

   assign rx_rate_in = skip_ff ? '0 : rx_quot;
   assign tx_rate_in = skip_ff ? '0 : tx_quot;

   assign hyst_ctl.update   = (state_ff == ST_FINISH) && rsp_free;
   assign hyst_ctl.up       = up_ff;
   assign hyst_ctl.storming = !skip_ff && ({1'b0, rx_quot} > threshold_ff);
   assign hyst_ctl.shutdown = shutdown_ff;

   bsd_port_state #(
      .NUM_PORTS (NUM_PORTS)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .port      (port_ff),
      .ctl       (hyst_ctl),
      .rx_count  (rx_ff),
      .tx_count  (tx_ff),
      .now_tick  (now_ff),
      .in_range  (in_range),
      .last_rx   (last_rx),
      .last_tx   (last_tx),
      .last_tick (last_tick),
      .response  (response)
   );

   bsd_serial_div u_rx_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (rx_scaled_ff),
      .divisor  (interval_ff),
      .done     (rx_done),
      .quotient (rx_quot)
   );

   bsd_serial_div u_tx_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (tx_scaled_ff),
      .divisor  (interval_ff),
      .done     (tx_done),
      .quotient (tx_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         threshold_ff <= '1;
         shutdown_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               bsd_pkg::CSR_THRESHOLD: threshold_ff <= csr_write_data;
               bsd_pkg::CSR_SHUTDOWN:  shutdown_ff  <= csr_write_data[0];
               default: ;
            endcase
         end

         if (rsp.ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         div_start_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  port_ff  <= req.port_index;
                  up_ff    <= req.port_up;
                  rx_ff    <= req.rx_bcast_count;
                  tx_ff    <= req.tx_bcast_count;
                  now_ff   <= req.now_tick;
                  state_ff <= ST_DELTA;
               end
            end
            ST_DELTA: begin
               skip_ff     <= !in_range || !up_ff;
               // a zero interval divides by one
               interval_ff <= (interval_in == '0) ? bsd_pkg::COUNT_W'(1) : interval_in;
               rx_delta_ff <= rx_delta_in;
               tx_delta_ff <= tx_delta_in;
               state_ff    <= (!in_range || !up_ff) ? ST_FINISH : ST_SCALE;
            end
            ST_SCALE: begin
               rx_scaled_ff <= bsd_pkg::RATE_W'(rx_delta_ff) *
                               bsd_pkg::RATE_W'(bsd_pkg::RATE_SCALE);
               tx_scaled_ff <= bsd_pkg::RATE_W'(tx_delta_ff) *
                               bsd_pkg::RATE_W'(bsd_pkg::RATE_SCALE);
               div_start_ff <= 1'b1;
               state_ff     <= ST_DIV;
            end
            ST_DIV: begin
               if (!div_start_ff && rx_done && tx_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_port_ff     <= port_ff;
                  rsp_response_ff <= response;
                  rsp_rx_rate_ff  <= rx_rate_in;
                  rsp_tx_rate_ff  <= tx_rate_in;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req.ready    = (state_ff == ST_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.port_out = rsp_port_ff;
   assign rsp.response = rsp_response_ff;
   assign rsp.rx_rate  = rsp_rx_rate_ff;
   assign rsp.tx_rate  = rsp_tx_rate_ff;

endmodule

// ===== bench/broadcast_storm_detector_tb.sv =====
`timescale 1ns / 1ps

module broadcast_storm_detector_tb;

   localparam int PORTS          = 4;
   localparam int IDLE_PCT       = 11;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int HOLDOFF_AFTER  = 150;
   localparam int SETTLE_CYCLES  = 50;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [bsd_pkg::PORT_W-1:0]  port_index;
      logic                        port_up;
      logic [bsd_pkg::COUNT_W-1:0] rx_count;
      logic [bsd_pkg::COUNT_W-1:0] tx_count;
      logic [bsd_pkg::COUNT_W-1:0] tick;
   } poll_type;

   typedef struct packed {
      logic [bsd_pkg::PORT_W-1:0] port;
      bsd_pkg::response_type      response;
      logic [bsd_pkg::RATE_W-1:0] rx_rate;
      logic [bsd_pkg::RATE_W-1:0] tx_rate;
   } verdict_type;

   logic clock;
   logic reset;
   logic                            csr_write_enable;
   logic [bsd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bsd_pkg::THRESH_W-1:0]    csr_write_data;

   bsd_req_if req_bus ();
   bsd_rsp_if rsp_bus ();

   broadcast_storm_detector #(.NUM_PORTS(PORTS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus.sink),
      .rsp              (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // storm tracker copy
   logic [bsd_pkg::THRESH_W-1:0]  cfg_threshold;
   logic                          cfg_shutdown;
   logic [bsd_pkg::COUNT_W-1:0]   seen_rx [PORTS];
   logic [bsd_pkg::COUNT_W-1:0]   seen_tx [PORTS];
   logic [bsd_pkg::COUNT_W-1:0]   seen_tick [PORTS];
   logic [bsd_pkg::OVER_W-1:0]    over_run [PORTS];
   logic [bsd_pkg::QUIET_W-1:0]   quiet_run [PORTS];
   logic [bsd_pkg::RECOVER_W-1:0] recover_run [PORTS];
   logic                          recover_live [PORTS];
   logic                          limited [PORTS];

   // poll generator history, mirrors what the block has seen
   logic [bsd_pkg::COUNT_W-1:0] gen_rx [PORTS];
   logic [bsd_pkg::COUNT_W-1:0] gen_tx [PORTS];
   logic [bsd_pkg::COUNT_W-1:0] gen_tick [PORTS];
   int unsigned                 gen_left [PORTS];
   bit                          gen_storm [PORTS];

   poll_type    pending_polls[$];
   verdict_type expected_verdicts[$];

   bit          req_taken;
   bit          no_idle;
   bit          holdoff_done;
   int unsigned holdoff_left;
   int unsigned verdicts_seen;
   int unsigned errors;
   int unsigned quiet_cycles;

   function automatic logic [bsd_pkg::COUNT_W-1:0] counter_delta(
         input logic [bsd_pkg::COUNT_W-1:0] cur,
         input logic [bsd_pkg::COUNT_W-1:0] prev);
      return (cur >= prev) ? cur - prev : 32'hFFFF_FFFF - (prev - cur);
   endfunction

   function automatic verdict_type predict_poll(input poll_type poll);
      verdict_type                 v;
      int unsigned                 k;
      logic [bsd_pkg::COUNT_W-1:0] span;
      logic [63:0]                 divisor;
      logic [63:0]                 rx_r;
      logic [63:0]                 tx_r;
      k = 32'(poll.port_index);
      v.port = poll.port_index;
      v.response = bsd_pkg::RESP_NONE;
      v.rx_rate = '0;
      v.tx_rate = '0;
      if (!poll.port_up) begin
         seen_rx[k] = '0;
         seen_tx[k] = '0;
         seen_tick[k] = '0;
         return v;
      end
      span = (poll.tick > seen_tick[k]) ? poll.tick - seen_tick[k]
                                        : 32'hFFFF_FFFF - (seen_tick[k] - poll.tick);
      divisor = (span == 0) ? 64'd1 : 64'(span);
      rx_r = (64'(counter_delta(poll.rx_count, seen_rx[k])) * bsd_pkg::RATE_SCALE) / divisor;
      tx_r = (64'(counter_delta(poll.tx_count, seen_tx[k])) * bsd_pkg::RATE_SCALE) / divisor;
      seen_rx[k] = poll.rx_count;
      seen_tx[k] = poll.tx_count;
      seen_tick[k] = poll.tick;
      if (rx_r > 64'(cfg_threshold)) begin
         over_run[k] = over_run[k] + 1'b1;
         quiet_run[k] = '0;
         recover_run[k] = '0;
         if (over_run[k] > bsd_pkg::OVER_LIMIT) begin
            if (cfg_shutdown) begin
               v.response = bsd_pkg::RESP_SHUTDOWN;
            end else if (!limited[k]) begin
               v.response = bsd_pkg::RESP_LIMIT;
               limited[k] = 1'b1;
            end
            over_run[k] = '0;
         end
      end else begin
         over_run[k] = '0;
         if (recover_live[k]) recover_run[k] = recover_run[k] + 1'b1;
         else recover_run[k] = '0;
         if (limited[k]) begin
            quiet_run[k] = quiet_run[k] + 1'b1;
            if (quiet_run[k] > bsd_pkg::QUIET_LIMIT) begin
               v.response = bsd_pkg::RESP_UNLIMIT;
               recover_live[k] = 1'b1;
               recover_run[k] = '0;
               limited[k] = 1'b0;
            end
         end
         if (recover_run[k] > bsd_pkg::RECOVER_LIMIT) begin
            v.response = bsd_pkg::RESP_ENDED;
            recover_live[k] = 1'b0;
            recover_run[k] = '0;
         end
      end
      v.rx_rate = rx_r[bsd_pkg::RATE_W-1:0];
      v.tx_rate = tx_r[bsd_pkg::RATE_W-1:0];
      return v;
   endfunction

   function automatic void add_poll(input int unsigned port, input bit up,
                                    input logic [bsd_pkg::COUNT_W-1:0] rx,
                                    input logic [bsd_pkg::COUNT_W-1:0] tx,
                                    input logic [bsd_pkg::COUNT_W-1:0] tick);
      poll_type p;
      p.port_index = port[bsd_pkg::PORT_W-1:0];
      p.port_up = up;
      p.rx_count = rx;
      p.tx_count = tx;
      p.tick = tick;
      pending_polls.push_back(p);
      gen_rx[port] = up ? rx : '0;
      gen_tx[port] = up ? tx : '0;
      gen_tick[port] = up ? tick : '0;
   endfunction

   // runs of storming and quiet polls per port, with some noise and downs
   function automatic void add_shaped_poll(input logic [bsd_pkg::THRESH_W-1:0] thr);
      int unsigned                 p;
      int unsigned                 roll;
      int unsigned                 iv;
      logic [63:0]                 want;
      logic [bsd_pkg::COUNT_W-1:0] drx;
      logic [bsd_pkg::COUNT_W-1:0] dtx;
      p = $urandom_range(PORTS - 1);
      roll = $urandom_range(99);
      if (roll < 4) begin
         add_poll(p, 1'b0, $urandom, $urandom, $urandom);
      end else if (roll < 9) begin
         add_poll(p, 1'($urandom_range(1)), $urandom, $urandom, $urandom);
      end else begin
         if (gen_left[p] == 0) begin
            gen_storm[p] = 1'($urandom_range(1));
            gen_left[p] = gen_storm[p] ? $urandom_range(9, 4) : $urandom_range(12, 1);
         end
         gen_left[p]--;
         iv = ($urandom_range(19) == 0) ? $urandom : $urandom_range(1000, 1);
         if (thr >= 40'h80000000) want = 64'hFFFF_FFFF;
         else if (gen_storm[p]) want = 64'(thr) * iv / 100 + 2 * 64'(iv);
         else want = 64'(thr) * iv / 200;
         drx = (want > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : want[bsd_pkg::COUNT_W-1:0];
         if (!gen_storm[p]) drx = $urandom_range(drx, 0);
         dtx = $urandom_range(50000);
         add_poll(p, 1'b1, gen_rx[p] + drx, gen_tx[p] + dtx, gen_tick[p] + iv);
      end
   endfunction

   task automatic write_csr(input bsd_pkg::csr_index_type idx,
                            input logic [bsd_pkg::THRESH_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == bsd_pkg::CSR_THRESHOLD) cfg_threshold = value;
      else cfg_shutdown = value[0];
   endtask

   task automatic wait_drained();
      while (pending_polls.size() != 0 || req_bus.valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [bsd_pkg::THRESH_W-1:0] thr, input bit mode,
                            input int unsigned count, input bit burst);
      wait_drained();
      write_csr(bsd_pkg::CSR_THRESHOLD, thr);
      write_csr(bsd_pkg::CSR_SHUTDOWN, bsd_pkg::THRESH_W'(mode));
      no_idle = burst;
      repeat (count) add_shaped_poll(thr);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sample request transfers and predict
   always @(posedge clock) begin
      poll_type taken;
      req_taken = !reset && req_bus.valid && req_bus.ready;
      if (req_taken) begin
         taken.port_index = req_bus.port_index;
         taken.port_up = req_bus.port_up;
         taken.rx_count = req_bus.rx_bcast_count;
         taken.tx_count = req_bus.tx_bcast_count;
         taken.tick = req_bus.now_tick;
         expected_verdicts.push_back(predict_poll(taken));
      end
   end

   always @(negedge clock) begin
      poll_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_polls.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = pending_polls.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.port_index <= nxt.port_index;
            req_bus.port_up <= nxt.port_up;
            req_bus.rx_bcast_count <= nxt.rx_count;
            req_bus.tx_bcast_count <= nxt.tx_count;
            req_bus.now_tick <= nxt.tick;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!holdoff_done && verdicts_seen >= HOLDOFF_AFTER) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= no_idle || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         verdicts_seen++;
         if (expected_verdicts.size() == 0) begin
            $error("rsp transfer with nothing expected, port_out %0d", rsp_bus.port_out);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_bus.port_out !== want.port) begin
               $error("port_out expected %0d actual %0d", want.port, rsp_bus.port_out);
               errors++;
            end
            if (rsp_bus.response !== want.response) begin
               $error("response expected %0d actual %0d", want.response, rsp_bus.response);
               errors++;
            end
            if (rsp_bus.rx_rate !== want.rx_rate) begin
               $error("rx_rate expected %0d actual %0d", want.rx_rate, rsp_bus.rx_rate);
               errors++;
            end
            if (rsp_bus.tx_rate !== want.tx_rate) begin
               $error("tx_rate expected %0d actual %0d", want.tx_rate, rsp_bus.tx_rate);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = bsd_pkg::CSR_THRESHOLD;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.port_index = '0;
      req_bus.port_up = 1'b0;
      req_bus.rx_bcast_count = '0;
      req_bus.tx_bcast_count = '0;
      req_bus.now_tick = '0;
      rsp_bus.ready = 1'b0;
      cfg_threshold = '1;
      cfg_shutdown = 1'b0;
      no_idle = 1'b0;
      holdoff_done = 1'b0;
      holdoff_left = 0;
      verdicts_seen = 0;
      errors = 0;
      quiet_cycles = 0;
      req_taken = 1'b0;
      for (int p = 0; p < PORTS; p++) begin
         seen_rx[p] = '0;
         seen_tx[p] = '0;
         seen_tick[p] = '0;
         over_run[p] = '0;
         quiet_run[p] = '0;
         recover_run[p] = '0;
         recover_live[p] = 1'b0;
         limited[p] = 1'b0;
         gen_rx[p] = '0;
         gen_tx[p] = '0;
         gen_tick[p] = '0;
         gen_left[p] = 0;
         gen_storm[p] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edge cases under reset settings: equal ticks, full-range rates,
      // zero interval, counter and tick wrap, down ports
      add_poll(0, 1'b1, 32'h0, 32'h0, 32'h0);
      add_poll(0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_poll(0, 1'b1, 32'h0, 32'h5, 32'h0);
      add_poll(0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_poll(1, 1'b1, 32'h8000_0000, 32'h1234, 32'h10);
      add_poll(1, 1'b1, 32'h10, 32'h0, 32'h8);
      add_poll(2, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h1);
      add_poll(3, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'h1);
      add_poll(3, 1'b0, 32'h0, 32'h0, 32'h0);
      add_poll(3, 1'b1, 32'h7, 32'h7, 32'hFFFF_FFFF);

      // limit, held limit, remove limit, storm ended
      wait_drained();
      write_csr(bsd_pkg::CSR_THRESHOLD, '0);
      write_csr(bsd_pkg::CSR_SHUTDOWN, '0);
      repeat (8) add_poll(1, 1'b1, gen_rx[1] + 1000, gen_tx[1], gen_tick[1] + 10);
      repeat (7) add_poll(1, 1'b1, gen_rx[1], gen_tx[1] + 3, gen_tick[1] + 10);

      run_phase(40'd5000, 1'b0, 200, 1'b0);
      run_phase(40'd5000, 1'b1, 200, 1'b0);
      run_phase(40'd0, 1'b1, 150, 1'b0);
      run_phase(40'd0, 1'b0, 150, 1'b0);
      run_phase('1, 1'b0, 100, 1'b0);
      run_phase({8'($urandom_range(255)), $urandom}, 1'($urandom_range(1)), 150, 1'b0);
      run_phase(40'd300, 1'b0, 250, 1'b1);
      wait_drained();

      if (errors == 0 && expected_verdicts.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
